// ===== rtl/tlcr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlcr_pkg: shared types and constants
// Fixed-point constants, register codes, controller states and the command
// and status words exchanged between controller and datapath.
// ----------------------------------------------------------------------------
package tlcr_pkg;

  localparam int PRICE_W  = 48;
  localparam int FEE_W    = 32;
  localparam int CHUNK_W  = 16;
  localparam int ACC_W    = 96;
  localparam int FEE_REGS = 3;
  localparam int DIV_STEPS = 48;
  localparam int CNT_W    = 6;

  localparam logic [PRICE_W-1:0] Q48_MAX      = '1;
  localparam logic [PRICE_W-1:0] ONE_Q32      = 48'h0001_0000_0000;
  localparam logic [FEE_W-1:0]   ONE_Q31      = 32'h8000_0000;
  // 2^64 shifted right by the 48 quotient bits, also the saturation bound
  localparam logic [PRICE_W-1:0] RCP_REM_INIT = 48'h0000_0001_0000;

  localparam logic [1:0] FEE_LAST_CHUNK = 2'd1;
  localparam logic [1:0] RUN_LAST_CHUNK = 2'd2;

  typedef enum logic [1:0] {
    CFG_LEG_IS_BUY = 2'd0,
    CFG_FEE0       = 2'd1,
    CFG_FEE1       = 2'd2,
    CFG_FEE2       = 2'd3
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_STORE,
    ST_FACT_LD,
    ST_FACT_MUL,
    ST_FACT_SAT,
    ST_RUN_LD,
    ST_RUN_MUL,
    ST_RUN_SAT,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic       capture;
    logic       div_step;
    logic       store;
    logic       fact_ld;
    logic       run_ld;
    logic       mul_step;
    logic [1:0] chunk;
    logic       fact_sat;
    logic       run_sat;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic leg_last;
    logic out_free;
  } status_t;

  // floor(acc / 2^31) saturated to 48 bits
  function automatic logic [PRICE_W-1:0] sat_shr31(input logic [ACC_W-1:0] acc);
    logic [PRICE_W-1:0] r;
    if (|acc[ACC_W-1:79]) r = Q48_MAX;
    else r = acc[78:31];
    return r;
  endfunction

  // floor(acc / 2^32) saturated to 48 bits
  function automatic logic [PRICE_W-1:0] sat_shr32(input logic [ACC_W-1:0] acc);
    logic [PRICE_W-1:0] r;
    if (|acc[ACC_W-1:80]) r = Q48_MAX;
    else r = acc[79:32];
    return r;
  endfunction

endpackage

// ===== rtl/tlcr_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlcr_if: channel interfaces
// Price update channel, result channel and register write channel, each
// with valid/ready and a source and sink modport.
// ----------------------------------------------------------------------------
interface tlcr_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  leg;
  logic [47:0] bid;
  logic [47:0] ask;
  modport source (output valid, output leg, output bid, output ask, input ready);
  modport sink (input valid, input leg, input bid, input ask, output ready);
endinterface

interface tlcr_out_if;
  logic        valid;
  logic        ready;
  logic [47:0] ratio;
  logic        all_priced;
  modport source (output valid, output ratio, output all_priced, input ready);
  modport sink (input valid, input ratio, input all_priced, output ready);
endinterface

interface tlcr_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/tlcr_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlcr_ctrl: sequencing controller
// Steps the datapath through the reciprocal divide, the per-leg fee and
// running-product multiplies and the result hand-off.
// ----------------------------------------------------------------------------
module tlcr_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  tlcr_pkg::status_t status,
  output tlcr_pkg::cmd_t    cmd
);

  tlcr_pkg::state_t             state, state_next;
  logic [tlcr_pkg::CNT_W-1:0]   div_cnt, div_cnt_next;
  logic [1:0]                   chunk_cnt, chunk_cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= tlcr_pkg::ST_IDLE;
      div_cnt   <= '0;
      chunk_cnt <= '0;
    end else begin
      state     <= state_next;
      div_cnt   <= div_cnt_next;
      chunk_cnt <= chunk_cnt_next;
    end
  end

  always_comb begin
    state_next     = state;
    div_cnt_next   = div_cnt;
    chunk_cnt_next = chunk_cnt;
    cmd            = '0;
    cmd.chunk      = chunk_cnt;
    in_ready       = 1'b0;
    unique case (state)
      tlcr_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture  = 1'b1;
          div_cnt_next = '0;
          state_next   = tlcr_pkg::ST_DIV;
        end
      end
      tlcr_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (div_cnt == tlcr_pkg::CNT_W'(tlcr_pkg::DIV_STEPS - 1)) begin
          state_next = tlcr_pkg::ST_STORE;
        end else begin
          div_cnt_next = div_cnt + tlcr_pkg::CNT_W'(1);
        end
      end
      tlcr_pkg::ST_STORE: begin
        cmd.store  = 1'b1;
        state_next = tlcr_pkg::ST_FACT_LD;
      end
      tlcr_pkg::ST_FACT_LD: begin
        cmd.fact_ld    = 1'b1;
        chunk_cnt_next = tlcr_pkg::FEE_LAST_CHUNK;
        state_next     = tlcr_pkg::ST_FACT_MUL;
      end
      tlcr_pkg::ST_FACT_MUL: begin
        cmd.mul_step = 1'b1;
        if (chunk_cnt == 2'd0) state_next = tlcr_pkg::ST_FACT_SAT;
        else chunk_cnt_next = chunk_cnt - 2'd1;
      end
      tlcr_pkg::ST_FACT_SAT: begin
        cmd.fact_sat = 1'b1;
        state_next   = tlcr_pkg::ST_RUN_LD;
      end
      tlcr_pkg::ST_RUN_LD: begin
        cmd.run_ld     = 1'b1;
        chunk_cnt_next = tlcr_pkg::RUN_LAST_CHUNK;
        state_next     = tlcr_pkg::ST_RUN_MUL;
      end
      tlcr_pkg::ST_RUN_MUL: begin
        cmd.mul_step = 1'b1;
        if (chunk_cnt == 2'd0) state_next = tlcr_pkg::ST_RUN_SAT;
        else chunk_cnt_next = chunk_cnt - 2'd1;
      end
      tlcr_pkg::ST_RUN_SAT: begin
        cmd.run_sat = 1'b1;
        if (status.leg_last) state_next = tlcr_pkg::ST_OUT;
        else state_next = tlcr_pkg::ST_FACT_LD;
      end
      tlcr_pkg::ST_OUT: begin
        // wait until the result register can take a new word
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = tlcr_pkg::ST_IDLE;
        end
      end
      default: state_next = tlcr_pkg::ST_IDLE;
    endcase
  end

endmodule

// ===== rtl/tlcr_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlcr_dp: cycle ratio datapath
// Leg price store, restoring reciprocal divider, shared 48x16 multiply-
// accumulate with saturation, config registers and result register.
// ----------------------------------------------------------------------------
module tlcr_dp #(
  parameter int NUM_LEGS = 3
) (
  input  logic              clk,
  input  logic              rst,
  input  tlcr_pkg::cmd_t    cmd,
  output tlcr_pkg::status_t status,
  input  logic [1:0]        in_leg,
  input  logic [47:0]       in_bid,
  input  logic [47:0]       in_ask,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [31:0]       cfg_data,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [47:0]       out_ratio,
  output logic              out_all_priced
);

  localparam int LEG_W = $clog2(NUM_LEGS);
  localparam int PW    = tlcr_pkg::PRICE_W;

  logic [1:0]               leg_q;
  logic [PW-1:0]            bid_q, ask_q, rem, quo;
  logic [PW-1:0]            bid_arr [NUM_LEGS];
  logic [PW-1:0]            rcp_arr [NUM_LEGS];
  logic [tlcr_pkg::FEE_W-1:0] fee [NUM_LEGS];
  logic [2:0]               leg_is_buy;
  logic [LEG_W-1:0]         leg_cnt;
  logic [PW-1:0]            running, factor, mul_a, mul_b;
  logic [tlcr_pkg::ACC_W-1:0] acc;
  logic                     priced;

  logic [PW:0]              rem_sh;
  logic                     rem_ge;
  logic [PW-1:0]            rcp_val, sel_mult;
  logic [NUM_LEGS-1:0]      buy_vec;
  logic [tlcr_pkg::CHUNK_W-1:0] chunk_sel;
  logic [63:0]              pprod;

  assign rem_sh = {rem, 1'b0};
  assign rem_ge = rem_sh >= {1'b0, ask_q};

  always_comb begin
    if (ask_q == '0) rcp_val = '0;
    else if (ask_q <= tlcr_pkg::RCP_REM_INIT) rcp_val = tlcr_pkg::Q48_MAX;
    else rcp_val = quo;
  end

  // legs past the register set are sell legs
  assign buy_vec  = NUM_LEGS'(leg_is_buy);
  assign sel_mult = buy_vec[leg_cnt] ? rcp_arr[leg_cnt] : bid_arr[leg_cnt];

  always_comb begin
    case (cmd.chunk)
      2'd0:    chunk_sel = mul_b[15:0];
      2'd1:    chunk_sel = mul_b[31:16];
      2'd2:    chunk_sel = mul_b[47:32];
      default: chunk_sel = '0;
    endcase
  end

  assign pprod = {16'b0, mul_a} * {48'b0, chunk_sel};

  assign status.leg_last = (int'(leg_cnt) == NUM_LEGS - 1);
  assign status.out_free = !out_valid || out_ready;

  // divider, multiply-accumulate and per-item working registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      leg_q <= in_leg;
      bid_q <= in_bid;
      ask_q <= in_ask;
      rem   <= tlcr_pkg::RCP_REM_INIT;
      quo   <= '0;
    end
    if (cmd.div_step) begin
      rem <= rem_ge ? PW'(rem_sh - {1'b0, ask_q}) : rem_sh[PW-1:0];
      quo <= {quo[PW-2:0], rem_ge};
    end
    if (cmd.store) begin
      running <= tlcr_pkg::ONE_Q32;
    end
    if (cmd.fact_ld) begin
      mul_a <= sel_mult;
      mul_b <= {16'b0, fee[leg_cnt]};
      acc   <= '0;
    end
    if (cmd.run_ld) begin
      mul_a <= running;
      mul_b <= factor;
      acc   <= '0;
    end
    if (cmd.mul_step) begin
      acc <= {acc[tlcr_pkg::ACC_W-17:0], 16'b0} + {32'b0, pprod};
    end
    if (cmd.fact_sat) begin
      factor <= tlcr_pkg::sat_shr31(acc);
    end
    if (cmd.run_sat) begin
      running <= tlcr_pkg::sat_shr32(acc);
    end
    if (cmd.out_load) begin
      out_ratio      <= priced ? running : '0;
      out_all_priced <= priced;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      leg_cnt <= '0;
      priced  <= 1'b0;
    end else if (cmd.store) begin
      leg_cnt <= '0;
      priced  <= 1'b1;
    end else begin
      if (cmd.fact_ld && sel_mult == '0) priced <= 1'b0;
      if (cmd.run_sat && !status.leg_last) leg_cnt <= leg_cnt + LEG_W'(1);
    end
  end

  // leg store and config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      leg_is_buy <= '0;
      for (int i = 0; i < NUM_LEGS; i++) begin
        bid_arr[i] <= '0;
        rcp_arr[i] <= '0;
        fee[i]     <= tlcr_pkg::ONE_Q31;
      end
    end else begin
      for (int i = 0; i < NUM_LEGS; i++) begin
        if (cmd.store && int'(leg_q) == i) begin
          bid_arr[i] <= bid_q;
          rcp_arr[i] <= rcp_val;
        end
        if (cfg_we && i < tlcr_pkg::FEE_REGS &&
            cfg_index == 2'(int'(tlcr_pkg::CFG_FEE0) + i)) begin
          fee[i] <= cfg_data;
        end
      end
      if (cfg_we && cfg_index == tlcr_pkg::CFG_LEG_IS_BUY) begin
        leg_is_buy <= cfg_data[2:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// ===== rtl/three_leg_cycle_ratio_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_leg_cycle_ratio_top: fee-adjusted triangular cycle ratio
// Stores per-leg bid and 1/ask, returns the product of fee-weighted legs.
// ----------------------------------------------------------------------------
// an accepted update runs the 48-step reciprocal divider, then per leg the fee
//   and running-product multiplies on the shared 48x16 multiplier; a new update
//   is accepted only after the result is loaded, which waits while out is stalled
// reset: synchronous; clears stored legs to zero, fees to 1.0, all legs to sell
// config writes are always ready and take effect at the next edge
module three_leg_cycle_ratio_top #(
  parameter int NUM_LEGS = 3
) (
  input logic        clk,
  input logic        rst,
  tlcr_in_if.sink    in,
  tlcr_out_if.source out,
  tlcr_cfg_if.sink   cfg
);

  tlcr_pkg::cmd_t    cmd;
  tlcr_pkg::status_t status;

  assign cfg.ready = 1'b1;

  tlcr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in.valid),
    .in_ready (in.ready),
    .status   (status),
    .cmd      (cmd)
  );

  tlcr_dp #(
    .NUM_LEGS (NUM_LEGS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .in_leg         (in.leg),
    .in_bid         (in.bid),
    .in_ask         (in.ask),
    .cfg_we         (cfg.valid),
    .cfg_index      (cfg.index),
    .cfg_data       (cfg.data),
    .out_valid      (out.valid),
    .out_ready      (out.ready),
    .out_ratio      (out.ratio),
    .out_all_priced (out.all_priced)
  );

endmodule

// ===== rtl/tlcr_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlcr_chk: port-level checker
// Watches the top level channels over time; bound to the top level.
// ----------------------------------------------------------------------------
module tlcr_chk (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [47:0] out_ratio,
  input logic        out_all_priced
);

  // result word holds while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_ratio) && $stable(out_all_priced))
    else $error("result word dropped or changed while stalled");

  // one update in flight at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again right after an accept");

  // a nonzero ratio needs every leg priced
  a_ratio_priced: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ratio != 48'd0 |-> out_all_priced)
    else $error("nonzero ratio with an unpriced leg");

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind three_leg_cycle_ratio_top tlcr_chk u_tlcr_chk (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in.valid),
  .in_ready       (in.ready),
  .out_valid      (out.valid),
  .out_ready      (out.ready),
  .out_ratio      (out.ratio),
  .out_all_priced (out.all_priced)
);
